// ===== hw/rtl/mte_pkg.sv =====
// Shared types and constants of the membership table engine.
// Request, response and table entry layouts; no dependencies.
`default_nettype none

package mte_pkg;

	// default table depth
	localparam int unsigned MTE_MAX_MEMBERS = 32;

	// operation codes
	typedef enum logic [1:0] {
		OP_ADD        = 2'd0,
		OP_CHECK_ADDR = 2'd1,
		OP_CHECK_FULL = 2'd2,
		OP_REMOVE     = 2'd3
	} mte_op_t;

	typedef struct packed {
		mte_op_t            opcode;
		logic        [31:0] ip_address;
		logic signed [31:0] time_stamp;
	} mte_req_t;

	typedef struct packed {
		logic       found;
		logic       add_dropped;
		logic [5:0] member_count;
	} mte_rsp_t;

	// one table row
	typedef struct packed {
		logic        [31:0] ip_address;
		logic signed [31:0] time_stamp;
	} mte_entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mte_mem.sv =====
// Member table storage: one write port, one registered read port.
// Uses mte_pkg for the entry layout.
`default_nettype none

module mte_mem
	import mte_pkg::*;
#(
	parameter int unsigned MAX_MEMBERS = MTE_MAX_MEMBERS,
	localparam int unsigned IDX_W = $clog2(MAX_MEMBERS)
) (
	input  wire logic             clk,
	input  wire logic             rd_en,
	input  wire logic [IDX_W-1:0] rd_addr,
	output mte_entry_t            rd_data,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  wire mte_entry_t       wr_data
);

	mte_entry_t mem_q [MAX_MEMBERS];

	// contents are undefined until written
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mte_ctrl.sv =====
// Sequencer of the membership table: scan, update, shift-down compaction.
// Uses mte_pkg; drives the table memory ports of mte_mem.
`default_nettype none

module mte_ctrl
	import mte_pkg::*;
#(
	parameter int unsigned MAX_MEMBERS = MTE_MAX_MEMBERS,
	localparam int unsigned IDX_W = $clog2(MAX_MEMBERS),
	localparam int unsigned CNT_W = $clog2(MAX_MEMBERS + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// request side
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire mte_req_t         req,
	// result toward the output register
	output logic                  res_valid,
	input  wire logic             res_ready,
	output mte_rsp_t              res,
	// table memory
	output logic                  rd_en,
	output logic [IDX_W-1:0]      rd_addr,
	input  wire mte_entry_t       rd_data,
	output logic                  wr_en,
	output logic [IDX_W-1:0]      wr_addr,
	output mte_entry_t            wr_data
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DECIDE = 5'b00100,
		ST_SHIFT  = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t             state_q;
	mte_op_t            op_q;
	logic        [31:0] addr_q;
	logic signed [31:0] stamp_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   rd_ptr_q;
	logic               hit_q;
	logic               dropped_q;
	logic [IDX_W-1:0]   where_q;
	logic               pend_s1;
	logic [IDX_W-1:0]   idx_s1;

	logic addr_eq;
	logic full_eq;
	logic match;
	logic pass_done;
	logic table_full;
	logic req_fire;

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;

	// compare the entry returned by the memory this cycle
	assign addr_eq = (rd_data.ip_address == addr_q);
	assign full_eq = addr_eq && (rd_data.time_stamp == stamp_q);
	assign match   = ((op_q == OP_ADD) || (op_q == OP_CHECK_ADDR)) ? addr_eq : full_eq;

	// a pass ends once every entry is issued and the last read is back
	assign pass_done  = (rd_ptr_q == count_q) && !pend_s1;
	assign table_full = (count_q >= CNT_W'(MAX_MEMBERS));

	// read issue during scan and shift
	assign rd_en   = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && (rd_ptr_q < count_q);
	assign rd_addr = rd_ptr_q[IDX_W-1:0];

	// write port: add/refresh in DECIDE, move down by one in SHIFT
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = where_q;
		wr_data = '{ip_address: addr_q, time_stamp: stamp_q};
		if (state_q == ST_DECIDE && op_q == OP_ADD) begin
			if (hit_q) begin
				wr_en = 1'b1;
			end else if (!table_full) begin
				wr_en   = 1'b1;
				wr_addr = count_q[IDX_W-1:0];
			end
		end else if (state_q == ST_SHIFT && pend_s1) begin
			wr_en   = 1'b1;
			wr_addr = idx_s1 - IDX_W'(1);
			wr_data = rd_data;
		end
	end

	// result
	assign res_valid        = (state_q == ST_DONE);
	assign res.found        = hit_q;
	assign res.add_dropped  = dropped_q;
	assign res.member_count = 6'(count_q);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			rd_ptr_q  <= '0;
			hit_q     <= 1'b0;
			dropped_q <= 1'b0;
			pend_s1   <= 1'b0;
		end else begin
			pend_s1 <= rd_en;
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						rd_ptr_q  <= '0;
						hit_q     <= 1'b0;
						dropped_q <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						rd_ptr_q <= rd_ptr_q + CNT_W'(1);
					end
					if (pend_s1 && match) begin
						hit_q <= 1'b1;
					end
					if (pass_done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					state_q <= ST_DONE;
					unique case (op_q)
						OP_ADD: begin
							if (!hit_q) begin
								if (table_full) begin
									dropped_q <= 1'b1;
								end else begin
									count_q <= count_q + CNT_W'(1);
								end
							end
						end
						OP_REMOVE: begin
							if (hit_q) begin
								rd_ptr_q <= CNT_W'(where_q) + CNT_W'(1);
								state_q  <= ST_SHIFT;
							end
						end
						default: begin
						end
					endcase
				end
				ST_SHIFT: begin
					if (rd_en) begin
						rd_ptr_q <= rd_ptr_q + CNT_W'(1);
					end
					if (pass_done) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request fields and match position
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q    <= req.opcode;
			addr_q  <= req.ip_address;
			stamp_q <= req.time_stamp;
		end
		idx_s1 <= rd_addr;
		// add keeps the last address match, remove the first full match
		if (state_q == ST_SCAN && pend_s1 && match) begin
			if (op_q == OP_ADD || !hit_q) begin
				where_q <= idx_s1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/membership_table_engine.sv =====
// Top level of the membership table engine.
// Uses mte_pkg, mte_ctrl and mte_mem; holds the response register.
//
//   channel   handshake              payload
//   request   req_valid / req_ready  req (mte_req_t)
//   response  rsp_valid / rsp_ready  rsp (mte_rsp_t)
//
// One request is worked at a time. A remove that hits shifts the later
// entries down one per cycle. The next request is taken in the cycle after
// the response leaves the sequencer; it accepts requests only when idle.
// Reset empties the table at once; no clearing pass is run.
// A finished response waits in the output register while the next request
// is taken; the sequencer holds only when that register is still occupied.
`default_nettype none

module membership_table_engine
	import mte_pkg::*;
#(
	parameter int unsigned MAX_MEMBERS = MTE_MAX_MEMBERS
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire mte_req_t req,
	output logic          rsp_valid,
	input  wire logic     rsp_ready,
	output mte_rsp_t      rsp
);

	localparam int unsigned IDX_W = $clog2(MAX_MEMBERS);

	logic             res_valid;
	logic             res_ready;
	mte_rsp_t         res;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	mte_entry_t       rd_data;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	mte_entry_t       wr_data;
	logic             rsp_valid_q;
	mte_rsp_t         rsp_q;

	mte_ctrl #(
		.MAX_MEMBERS(MAX_MEMBERS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	mte_mem #(
		.MAX_MEMBERS(MAX_MEMBERS)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// output register: free when empty or being taken
	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mte_checker.sv =====
// Port-level checks for membership_table_engine, attached by bind.
// Uses mte_pkg for the response layout.
`default_nettype none

module mte_checker
	import mte_pkg::*;
#(
	parameter int unsigned MAX_MEMBERS = MTE_MAX_MEMBERS
) (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     req_valid,
	input wire logic     req_ready,
	input wire logic     rsp_valid,
	input wire logic     rsp_ready,
	input wire mte_rsp_t rsp
);

	// a stalled response holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// one request at a time: no request taken right after another
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while one is in progress");

	// a dropped add means a full table and no match
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.add_dropped |->
			!rsp.found && (rsp.member_count == 6'(MAX_MEMBERS)))
		else $error("dropped add without a full table");

	// count stays within the table depth
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (MAX_MEMBERS > 63) || (32'(rsp.member_count) <= MAX_MEMBERS))
		else $error("member count above table depth");

endmodule

bind membership_table_engine mte_checker #(
	.MAX_MEMBERS(MAX_MEMBERS)
) u_mte_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire

// ===== tb/membership_table_engine_tb.sv =====
// Self-checking testbench for membership_table_engine: directed table, then random requests.
// Responses are checked against the directed table's expected values or an in-bench model of the member table.
// Depends on mte_pkg and the engine RTL only.
`default_nettype none

module membership_table_engine_tb;
	import mte_pkg::*;

	localparam int TABLE_DEPTH = MTE_MAX_MEMBERS;
	localparam int POOL_SIZE   = 48;
	localparam int RAND_ITEMS  = 600;
	localparam int EPISODE     = 80;
	localparam int HOLD_AT     = 300;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_WAIT  = 2 * TABLE_DEPTH + 40;
	localparam int CYCLE_LIMIT = 300000;

	// one row of the directed table; want is used only where typed is set
	typedef struct packed {
		mte_op_t     op;
		logic [31:0] ip;
		logic [31:0] ts;
		bit          typed;
		mte_rsp_t    want;
	} stim_row_t;

	localparam int DIR_ROWS = 24;
	localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
		'{OP_CHECK_ADDR, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 6'd0}},
		'{OP_REMOVE,     32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 6'd0}},
		'{OP_CHECK_FULL, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, '{1'b0, 1'b0, 6'd0}},
		'{OP_ADD,        32'h0000_0000, 32'h8000_0000, 1'b1, '{1'b0, 1'b0, 6'd1}},
		'{OP_ADD,        32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, '{1'b0, 1'b0, 6'd2}},
		// refresh of a present address
		'{OP_ADD,        32'h0000_0000, 32'h0000_0005, 1'b1, '{1'b1, 1'b0, 6'd2}},
		// address check ignores the stamp
		'{OP_CHECK_ADDR, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b0, 6'd2}},
		'{OP_CHECK_FULL, 32'h0000_0000, 32'h8000_0000, 1'b1, '{1'b0, 1'b0, 6'd2}},
		'{OP_CHECK_FULL, 32'h0000_0000, 32'h0000_0005, 1'b1, '{1'b1, 1'b0, 6'd2}},
		// remove with the wrong stamp leaves the table alone
		'{OP_REMOVE,     32'hFFFF_FFFF, 32'h8000_0000, 1'b1, '{1'b0, 1'b0, 6'd2}},
		'{OP_ADD,        32'hC0A8_0001, 32'h0000_0005, 1'b1, '{1'b0, 1'b0, 6'd3}},
		'{OP_ADD,        32'h0A00_0001, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 6'd4}},
		// remove the first entry, the rest shift down
		'{OP_REMOVE,     32'h0000_0000, 32'h0000_0005, 1'b1, '{1'b1, 1'b0, 6'd3}},
		'{OP_CHECK_ADDR, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 6'd3}},
		'{OP_CHECK_FULL, 32'hC0A8_0001, 32'h0000_0005, 1'b1, '{1'b1, 1'b0, 6'd3}},
		'{OP_REMOVE,     32'h0A00_0001, 32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b0, 6'd2}},
		'{OP_REMOVE,     32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, '{1'b1, 1'b0, 6'd1}},
		'{OP_ADD,        32'h0000_0001, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 6'd2}},
		'{OP_REMOVE,     32'hC0A8_0001, 32'h0000_0005, 1'b1, '{1'b1, 1'b0, 6'd1}},
		'{OP_REMOVE,     32'h0000_0001, 32'h0000_0000, 1'b1, '{1'b1, 1'b0, 6'd0}},
		'{OP_CHECK_ADDR, 32'h0000_0001, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 6'd0}},
		'{OP_ADD,        32'h5555_5555, 32'h5555_5555, 1'b0, '{1'b0, 1'b0, 6'd0}},
		'{OP_ADD,        32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b0, '{1'b0, 1'b0, 6'd0}},
		'{OP_CHECK_FULL, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b0, '{1'b0, 1'b0, 6'd0}}
	};

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	mte_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	mte_rsp_t rsp;

	// model of the member table
	logic [31:0] member_addr [TABLE_DEPTH];
	logic [31:0] member_stamp [TABLE_DEPTH];
	int          member_total = 0;

	logic [31:0] addr_pool [POOL_SIZE];
	mte_rsp_t    pending_rsp [$];
	int          mismatches = 0;
	int          cycle_count = 0;
	bit          calm = 1'b0;

	membership_table_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// applies one request to the table model and returns its response
	function automatic mte_rsp_t apply_member_op(input mte_req_t r);
		mte_rsp_t res;
		int       hit_at;
		res = '0;
		hit_at = -1;
		case (r.opcode)
			OP_ADD: begin
				// last entry with this address
				for (int i = 0; i < member_total; i++)
					if (member_addr[i] == r.ip_address) hit_at = i;
				if (hit_at >= 0) begin
					member_stamp[hit_at] = r.time_stamp;
					res.found = 1'b1;
				end else if (member_total < TABLE_DEPTH) begin
					member_addr[member_total] = r.ip_address;
					member_stamp[member_total] = r.time_stamp;
					member_total++;
				end else begin
					res.add_dropped = 1'b1;
				end
			end
			OP_CHECK_ADDR: begin
				for (int i = 0; i < member_total; i++)
					if (member_addr[i] == r.ip_address) res.found = 1'b1;
			end
			OP_CHECK_FULL: begin
				for (int i = 0; i < member_total; i++)
					if (member_addr[i] == r.ip_address && member_stamp[i] == r.time_stamp)
						res.found = 1'b1;
			end
			default: begin
				// first entry with this address and stamp, then compact
				for (int i = member_total - 1; i >= 0; i--)
					if (member_addr[i] == r.ip_address && member_stamp[i] == r.time_stamp)
						hit_at = i;
				if (hit_at >= 0) begin
					for (int i = hit_at; i + 1 < member_total; i++) begin
						member_addr[i] = member_addr[i + 1];
						member_stamp[i] = member_stamp[i + 1];
					end
					member_total--;
					res.found = 1'b1;
				end
			end
		endcase
		res.member_count = 6'(member_total);
		return res;
	endfunction

	function automatic int draw_wait();
		if (calm) return 0;
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
	endfunction

	function automatic logic [31:0] pick_stamp();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// random request; filling favors adds, otherwise removes of live entries dominate
	task automatic make_request(input bit filling, output mte_req_t r);
		int pick;
		int idx;
		pick = $urandom_range(0, 99);
		r.opcode = OP_CHECK_ADDR;
		r.ip_address = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
		r.time_stamp = pick_stamp();
		if (pick < 8) begin
			// noise
			r.opcode = mte_op_t'($urandom_range(0, 3));
			r.ip_address = $urandom;
		end else if (pick < (filling ? 75 : 30)) begin
			r.opcode = OP_ADD;
		end else if (pick < (filling ? 85 : 80) && member_total > 0) begin
			idx = $urandom_range(0, member_total - 1);
			r.opcode = ($urandom_range(0, 2) == 0) ? OP_CHECK_FULL : OP_REMOVE;
			r.ip_address = member_addr[idx];
			r.time_stamp = member_stamp[idx];
		end else begin
			// present address with a likely wrong stamp, or a pool address
			r.opcode = mte_op_t'($urandom_range(1, 3));
			if (member_total > 0 && $urandom_range(0, 1) == 1)
				r.ip_address = member_addr[$urandom_range(0, member_total - 1)];
		end
	endtask

	// offers one request, waits for the handshake, then records the expected response
	task automatic offer_request(input mte_req_t r, input bit typed, input mte_rsp_t want);
		int       gap;
		mte_rsp_t got;
		gap = draw_wait();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		got = apply_member_op(r);
		pending_rsp.insert(pending_rsp.size(), typed ? want : got);
	endtask

	// response side: random stalls, one long hold-off, field checks
	initial begin
		int       stall;
		int       rsp_seen;
		mte_rsp_t exp_rsp;
		rsp_seen = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_wait();
			if (rsp_seen == HOLD_AT) stall = HOLD_CYCLES;
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			rsp_seen++;
			if (pending_rsp.size() == 0) begin
				$error("response with no request outstanding: %p", rsp);
				mismatches++;
			end else begin
				exp_rsp = pending_rsp.pop_front();
				if (rsp.found !== exp_rsp.found) begin
					$error("found: expected %0d, got %0d", exp_rsp.found, rsp.found);
					mismatches++;
				end
				if (rsp.add_dropped !== exp_rsp.add_dropped) begin
					$error("add_dropped: expected %0d, got %0d",
						exp_rsp.add_dropped, rsp.add_dropped);
					mismatches++;
				end
				if (rsp.member_count !== exp_rsp.member_count) begin
					$error("member_count: expected %0d, got %0d",
						exp_rsp.member_count, rsp.member_count);
					mismatches++;
				end
			end
		end
	end

	// request side
	initial begin
		mte_req_t r;
		for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = $urandom;
		addr_pool[0] = 32'h0000_0000;
		addr_pool[1] = 32'hFFFF_FFFF;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < DIR_ROWS; i++) begin
			r.opcode = DIR_TABLE[i].op;
			r.ip_address = DIR_TABLE[i].ip;
			r.time_stamp = DIR_TABLE[i].ts;
			offer_request(r, DIR_TABLE[i].typed, DIR_TABLE[i].want);
		end

		// random part: alternating fill and drain episodes, one stretch without idling
		for (int k = 0; k < RAND_ITEMS; k++) begin
			calm = (k >= 250 && k < 330);
			make_request(((k / EPISODE) % 2) == 0, r);
			offer_request(r, 1'b0, '0);
		end
		calm = 1'b0;
		req_valid <= 1'b0;

		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
